FILE: rtl/core/kct_pkg.sv
// Shared types and constants for the key count table.
package kct_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 32;
    localparam int CNT_W   = 32;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0]       OP_ADD    = 2'd0;
    localparam logic [1:0]       OP_DEL    = 2'd1;
    localparam logic [1:0]       OP_SEARCH = 2'd2;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [QC_W-1:0]  Q_FULL    = QC_W'(Q_DEPTH);

    typedef enum logic [1:0] {
        K_ADD,
        K_DEL,
        K_SEARCH,
        K_INVALID
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: rtl/core/key_count_table_core.sv
// Top level of the key count table: front end, command queue and table engine.
// An accepted word is first written into the command queue; the table engine then registers its result.
// Throughput: one word per cycle while busy is low; the engine compares all slots in parallel.
// Busy rises only when the two-word command queue is full.
// Reset is synchronous and active low; it empties the queue and frees all slots.
// The result strobe lasts exactly one cycle and cannot be stalled.
module key_count_table_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_op,
    input  logic signed [kct_pkg::KEY_W-1:0] i_key,
    output logic                        o_done,
    output logic                        o_ok,
    output logic [kct_pkg::CNT_W-1:0]   o_count
);
    import kct_pkg::*;

    t_cmd    w_push_cmd;
    t_cmd    w_head_cmd;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;

    kct_front u_front (
        .i_start  (start),
        .i_op     (i_op),
        .i_key    (i_key),
        .i_q_stat (w_q_stat),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    kct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_q_stat)
    );

    kct_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_head_cmd),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_done   (o_done),
        .o_ok     (o_ok),
        .o_count  (o_count)
    );

endmodule

FILE: rtl/core/kct_front.sv
// Command front end: accepts a word and classifies its operation.
module kct_front (
    input  logic                        i_start,
    input  logic [1:0]                  i_op,
    input  logic signed [kct_pkg::KEY_W-1:0] i_key,
    input  kct_pkg::t_q_stat            i_q_stat,
    output logic                        o_busy,
    output logic                        o_push,
    output kct_pkg::t_cmd               o_cmd
);
    import kct_pkg::*;

    t_kind w_kind;

    always_comb begin
        unique case (i_op)
            OP_ADD:    w_kind = K_ADD;
            OP_DEL:    w_kind = K_DEL;
            OP_SEARCH: w_kind = K_SEARCH;
            default:   w_kind = K_INVALID;
        endcase
    end

    assign o_busy     = i_q_stat.full;
    assign o_push     = i_start && !i_q_stat.full;
    assign o_cmd.kind = w_kind;
    assign o_cmd.key  = $unsigned(i_key);

endmodule

FILE: rtl/core/kct_queue.sv
// Short command queue between the front end and the table engine.
module kct_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  kct_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output kct_pkg::t_cmd     o_cmd,
    output kct_pkg::t_q_stat  o_stat
);
    import kct_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [QC_W-1:0] r_fill;
    logic [QC_W-1:0] n_fill;

    always_comb begin
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + QC_W'(1);
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rptr];
    assign o_stat.full  = (r_fill == Q_FULL);
    assign o_stat.empty = (r_fill == '0);

endmodule

FILE: rtl/core/kct_back.sv
// Table engine: compares all slots at once and applies add, delete or search; an invalid op reports failure.
module kct_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  kct_pkg::t_cmd             i_cmd,
    input  kct_pkg::t_q_stat          i_q_stat,
    output logic                      o_pop,
    output logic                      o_done,
    output logic                      o_ok,
    output logic [kct_pkg::CNT_W-1:0] o_count
);
    import kct_pkg::*;

    logic [KEY_W-1:0]   r_key [ENTRIES];
    logic [CNT_W-1:0]   r_cnt [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0]   n_key [ENTRIES];
    logic [CNT_W-1:0]   n_cnt [ENTRIES];
    logic [ENTRIES-1:0] n_valid;
    logic               r_done;
    logic               r_ok;
    logic [CNT_W-1:0]   r_count;
    logic               n_ok;
    logic [CNT_W-1:0]   n_count;

    logic               w_pop;
    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_free;
    logic [ENTRIES-1:0] w_from_hit;
    logic               w_hit;
    logic               w_full;
    logic [CNT_W-1:0]   w_sel_cnt;

    assign w_pop = !i_q_stat.empty;

    always_comb begin
        w_sel_cnt = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == i_cmd.key);
            w_sel_cnt  = w_sel_cnt | (w_match[i] ? r_cnt[i] : '0);
        end
    end

    // Valid slots form a prefix, so the first free slot follows the last valid one.
    assign w_free     = ~r_valid & {r_valid[ENTRIES-2:0], 1'b1};
    assign w_from_hit = ~(w_match - ENTRIES'(1));
    assign w_hit      = |w_match;
    assign w_full     = r_valid[ENTRIES-1];

    always_comb begin
        n_key   = r_key;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        n_ok    = 1'b0;
        n_count = '0;
        if (w_pop) begin
            unique case (i_cmd.kind)
                K_ADD: begin
                    if (w_hit) begin
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (w_match[j] && (r_cnt[j] != CNT_MAX)) begin
                                n_cnt[j] = r_cnt[j] + CNT_W'(1);
                            end
                        end
                        n_ok = 1'b1;
                    end else if (!w_full) begin
                        for (int j = 0; j < ENTRIES; j++) begin
                            if (w_free[j]) begin
                                n_key[j]   = i_cmd.key;
                                n_cnt[j]   = CNT_W'(1);
                                n_valid[j] = 1'b1;
                            end
                        end
                        n_ok = 1'b1;
                    end
                end
                K_DEL: begin
                    if (w_hit) begin
                        for (int j = 0; j < ENTRIES - 1; j++) begin
                            if (w_from_hit[j]) begin
                                n_key[j]   = r_key[j+1];
                                n_cnt[j]   = r_cnt[j+1];
                                n_valid[j] = r_valid[j+1];
                            end
                        end
                        n_valid[ENTRIES-1] = 1'b0;
                        n_ok = 1'b1;
                    end
                end
                K_SEARCH: begin
                    n_ok    = 1'b1;
                    n_count = w_sel_cnt;
                end
                K_INVALID: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_done  <= w_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_cnt   <= n_cnt;
        r_ok    <= n_ok;
        r_count <= n_count;
    end

    assign o_pop   = w_pop;
    assign o_done  = r_done;
    assign o_ok    = r_ok;
    assign o_count = r_count;

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_valid >> 1) & ~r_valid) == '0)
        else $error("Valid slots do not form a prefix.");

    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> $onehot0(w_match))
        else $error("A key matches more than one slot.");

    a_done_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && w_pop |=> r_done)
        else $error("A dequeued word produced no result.");

    a_full_add_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && w_pop && (i_cmd.kind == K_ADD) && !w_hit && w_full |=> !r_ok)
        else $error("Add of a new key into a full table reported success.");

    a_count_only_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && w_pop && (i_cmd.kind != K_SEARCH) |=> (r_count == '0))
        else $error("Nonzero count returned for an operation other than search.");

endmodule

FILE: test/tb.sv
// Self-checking testbench for the key count table core: directed and random command words.
module tb;
    import kct_pkg::*;

    localparam logic [1:0] OP_INVALID  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         POOL_SIZE   = 32;

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] count;
    } reply_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              i_op;
    logic signed [KEY_W-1:0] i_key;
    logic                    o_done;
    logic                    o_ok;
    logic [CNT_W-1:0]        o_count;

    logic [KEY_W-1:0] tbl_key  [ENTRIES];
    logic [CNT_W-1:0] tbl_cnt  [ENTRIES];
    logic             tbl_used [ENTRIES];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    reply_t           pending_replies [$];

    int errors         = 0;
    int cycles         = 0;
    int words_sent     = 0;
    int replies_seen   = 0;
    int burst_left     = 0;
    int full_rejects   = 0;
    int absent_deletes = 0;
    int search_hits    = 0;
    int invalid_ops    = 0;

    key_count_table_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_op    (i_op),
        .i_key   (i_key),
        .o_done  (o_done),
        .o_ok    (o_ok),
        .o_count (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic reply_t table_update(input logic [1:0] op, input logic [KEY_W-1:0] key);
        reply_t r;
        int     hit;
        int     i;
        r   = '0;
        hit = ENTRIES;
        for (i = 0; i < ENTRIES; i++) begin
            if (hit == ENTRIES && tbl_used[i] && tbl_key[i] == key) begin
                hit = i;
            end
        end
        case (op)
            OP_ADD: begin
                if (hit < ENTRIES) begin
                    if (tbl_cnt[hit] != CNT_MAX) begin
                        tbl_cnt[hit] = tbl_cnt[hit] + 1'b1;
                    end
                    r.ok = 1'b1;
                end else begin
                    for (i = 0; i < ENTRIES && !r.ok; i++) begin
                        if (!tbl_used[i]) begin
                            tbl_key[i]  = key;
                            tbl_cnt[i]  = 1;
                            tbl_used[i] = 1'b1;
                            r.ok        = 1'b1;
                        end
                    end
                    if (!r.ok) begin
                        full_rejects++;
                    end
                end
            end
            OP_DEL: begin
                if (hit < ENTRIES) begin
                    for (i = hit; i < ENTRIES - 1; i++) begin
                        tbl_key[i]  = tbl_key[i+1];
                        tbl_cnt[i]  = tbl_cnt[i+1];
                        tbl_used[i] = tbl_used[i+1];
                    end
                    tbl_key[ENTRIES-1]  = '0;
                    tbl_cnt[ENTRIES-1]  = '0;
                    tbl_used[ENTRIES-1] = 1'b0;
                    r.ok = 1'b1;
                end else begin
                    absent_deletes++;
                end
            end
            OP_SEARCH: begin
                r.ok = 1'b1;
                if (hit < ENTRIES) begin
                    r.count = tbl_cnt[hit];
                    search_hits++;
                end
            end
            default: begin
                invalid_ops++;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        reply_t want;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_replies.size() == 0) begin
                    $error("result word with no pending command: ok %0b count %0h", o_ok, o_count);
                    errors++;
                end else begin
                    want = pending_replies.pop_front();
                    replies_seen++;
                    if (o_ok !== want.ok) begin
                        $error("ok: expected %0b, actual %0b", want.ok, o_ok);
                        errors++;
                    end
                    if (o_count !== want.count) begin
                        $error("count: expected %0h, actual %0h", want.count, o_count);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                pending_replies.push_back(table_update(i_op, i_key));
            end
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [KEY_W-1:0] key);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        i_op  <= op;
        i_key <= key;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_word(OP_SEARCH, '0);
        send_word(OP_DEL, '0);
        send_word(OP_INVALID, '1);
    endtask

    task automatic test_edge_keys();
        send_word(OP_ADD, '0);
        send_word(OP_ADD, '0);
        send_word(OP_SEARCH, '0);
        send_word(OP_ADD, 32'h7FFF_FFFF);
        send_word(OP_ADD, 32'h8000_0000);
        send_word(OP_DEL, '0);
        send_word(OP_SEARCH, 32'h8000_0000);
        wait_drained();
    endtask

    task automatic test_full_table();
        int i;
        for (i = 0; i < ENTRIES - 2; i++) begin
            send_word(OP_ADD, 32'h5A00_0000 | i);
        end
        send_word(OP_ADD, 32'h5A00_00FF);
        send_word(OP_ADD, 32'h7FFF_FFFF);
        send_word(OP_DEL, 32'h5A00_0003);
        send_word(OP_SEARCH, 32'h5A00_0004);
        wait_drained();
    endtask

    task automatic run_random(input int n_words, input int pool_used,
                              input int add_pct, input int del_pct);
        int               i;
        int               roll;
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        for (i = 0; i < n_words; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct) begin
                op = OP_ADD;
            end else if (roll < add_pct + del_pct) begin
                op = OP_DEL;
            end else if (roll < 96) begin
                op = OP_SEARCH;
            end else begin
                op = OP_INVALID;
            end
            if ($urandom_range(0, 9) < 8) begin
                key = key_pool[$urandom_range(0, pool_used - 1)];
            end else begin
                key = $urandom;
            end
            send_word(op, key);
        end
        wait_drained();
    endtask

    task automatic test_hot_keys();
        run_random(150, 6, 50, 20);
    endtask

    task automatic test_overflow();
        run_random(200, 24, 55, 15);
    endtask

    task automatic test_churn();
        run_random(150, 20, 35, 35);
    endtask

    task automatic test_drain_out();
        run_random(100, 24, 15, 55);
    endtask

    initial begin
        int i;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_op    <= OP_ADD;
        i_key   <= '0;
        for (i = 0; i < ENTRIES; i++) begin
            tbl_key[i]  = '0;
            tbl_cnt[i]  = '0;
            tbl_used[i] = 1'b0;
        end
        key_pool[0] = '0;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = '1;
        for (i = 4; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_edge_keys();
        test_full_table();
        test_hot_keys();
        test_overflow();
        test_churn();
        test_drain_out();

        $display("Sent %0d command words and checked %0d result words, with bursty input timing.",
                 words_sent, replies_seen);
        $display("Saw %0d full-table rejects, %0d absent deletes, %0d search hits, %0d bad ops.",
                 full_rejects, absent_deletes, search_hits, invalid_ops);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/kct_pkg.sv
rtl/core/kct_front.sv
rtl/core/kct_queue.sv
rtl/core/kct_back.sv
rtl/core/key_count_table_core.sv
test/tb.sv
